// ===== rtl/core/gtpr_pkg.sv =====
// gtpr_pkg: shared types, constants and the 6x8 font table for the glyph text renderer
// no dependencies; imported by the top level and the testbench
`default_nettype none

package gtpr_pkg;

  localparam int unsigned FIRST_CODE  = 32;
  localparam int unsigned ROM_ROWS    = 92;
  localparam int unsigned GLYPH_COLS  = 6;
  localparam int unsigned GLYPH_ROWS  = 8;
  localparam int unsigned CUR_W       = 16;
  localparam int unsigned CNT_W       = 6;
  localparam int unsigned CFG_W       = 9;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam logic [7:0]  QMARK_CODE  = 8'h3f;
  localparam logic [CUR_W-1:0] STOP_MARGIN = 16'd6;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 3'd0,
    CFG_HEIGHT = 3'd1,
    CFG_COLOFS = 3'd2,
    CFG_ROWOFS = 3'd3,
    CFG_ENABLE = 3'd4
  } cfg_idx_e;

  typedef logic [GLYPH_COLS-1:0][7:0] glyph_t;

  // one character waiting for or held in the pixel walker
  typedef struct packed {
    glyph_t      glyph;
    logic [5:0]  col_mask;
    logic [7:0]  row_mask;
    logic [2:0]  last_col;
    logic [2:0]  last_row;
    logic [15:0] base_x;
    logic [15:0] base_y;
    logic [15:0] fg;
    logic [15:0] bg;
  } job_t;

  localparam logic [7:0] FONT_ROM [ROM_ROWS][GLYPH_COLS] = '{
    '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00}, '{8'h00,8'h00,8'h00,8'h2f,8'h00,8'h00},
    '{8'h00,8'h00,8'h07,8'h00,8'h07,8'h00}, '{8'h00,8'h14,8'h7f,8'h14,8'h7f,8'h14},
    '{8'h00,8'h24,8'h2a,8'h7f,8'h2a,8'h12}, '{8'h00,8'h62,8'h64,8'h08,8'h13,8'h23},
    '{8'h00,8'h36,8'h49,8'h55,8'h22,8'h50}, '{8'h00,8'h00,8'h05,8'h03,8'h00,8'h00},
    '{8'h00,8'h00,8'h1c,8'h22,8'h41,8'h00}, '{8'h00,8'h00,8'h41,8'h22,8'h1c,8'h00},
    '{8'h00,8'h14,8'h08,8'h3e,8'h08,8'h14}, '{8'h00,8'h08,8'h08,8'h3e,8'h08,8'h08},
    '{8'h00,8'h00,8'h00,8'ha0,8'h60,8'h00}, '{8'h00,8'h08,8'h08,8'h08,8'h08,8'h08},
    '{8'h00,8'h00,8'h60,8'h60,8'h00,8'h00}, '{8'h00,8'h20,8'h10,8'h08,8'h04,8'h02},
    '{8'h00,8'h3e,8'h51,8'h49,8'h45,8'h3e}, '{8'h00,8'h00,8'h42,8'h7f,8'h40,8'h00},
    '{8'h00,8'h42,8'h61,8'h51,8'h49,8'h46}, '{8'h00,8'h21,8'h41,8'h45,8'h4b,8'h31},
    '{8'h00,8'h18,8'h14,8'h12,8'h7f,8'h10}, '{8'h00,8'h27,8'h45,8'h45,8'h45,8'h39},
    '{8'h00,8'h3c,8'h4a,8'h49,8'h49,8'h30}, '{8'h00,8'h01,8'h71,8'h09,8'h05,8'h03},
    '{8'h00,8'h36,8'h49,8'h49,8'h49,8'h36}, '{8'h00,8'h06,8'h49,8'h49,8'h29,8'h1e},
    '{8'h00,8'h00,8'h36,8'h36,8'h00,8'h00}, '{8'h00,8'h00,8'h56,8'h36,8'h00,8'h00},
    '{8'h00,8'h08,8'h14,8'h22,8'h41,8'h00}, '{8'h00,8'h14,8'h14,8'h14,8'h14,8'h14},
    '{8'h00,8'h00,8'h41,8'h22,8'h14,8'h08}, '{8'h00,8'h02,8'h01,8'h51,8'h09,8'h06},
    '{8'h00,8'h32,8'h49,8'h59,8'h51,8'h3e}, '{8'h00,8'h7c,8'h12,8'h11,8'h12,8'h7c},
    '{8'h00,8'h7f,8'h49,8'h49,8'h49,8'h36}, '{8'h00,8'h3e,8'h41,8'h41,8'h41,8'h22},
    '{8'h00,8'h7f,8'h41,8'h41,8'h22,8'h1c}, '{8'h00,8'h7f,8'h49,8'h49,8'h49,8'h41},
    '{8'h00,8'h7f,8'h09,8'h09,8'h09,8'h01}, '{8'h00,8'h3e,8'h41,8'h49,8'h49,8'h7a},
    '{8'h00,8'h7f,8'h08,8'h08,8'h08,8'h7f}, '{8'h00,8'h00,8'h41,8'h7f,8'h41,8'h00},
    '{8'h00,8'h20,8'h40,8'h41,8'h3f,8'h01}, '{8'h00,8'h7f,8'h08,8'h14,8'h22,8'h41},
    '{8'h00,8'h7f,8'h40,8'h40,8'h40,8'h40}, '{8'h00,8'h7f,8'h02,8'h0c,8'h02,8'h7f},
    '{8'h00,8'h7f,8'h04,8'h08,8'h10,8'h7f}, '{8'h00,8'h3e,8'h41,8'h41,8'h41,8'h3e},
    '{8'h00,8'h7f,8'h09,8'h09,8'h09,8'h06}, '{8'h00,8'h3e,8'h41,8'h51,8'h21,8'h5e},
    '{8'h00,8'h7f,8'h09,8'h19,8'h29,8'h46}, '{8'h00,8'h46,8'h49,8'h49,8'h49,8'h31},
    '{8'h00,8'h01,8'h01,8'h7f,8'h01,8'h01}, '{8'h00,8'h3f,8'h40,8'h40,8'h40,8'h3f},
    '{8'h00,8'h1f,8'h20,8'h40,8'h20,8'h1f}, '{8'h00,8'h3f,8'h40,8'h38,8'h40,8'h3f},
    '{8'h00,8'h63,8'h14,8'h08,8'h14,8'h63}, '{8'h00,8'h07,8'h08,8'h70,8'h08,8'h07},
    '{8'h00,8'h61,8'h51,8'h49,8'h45,8'h43}, '{8'h00,8'h00,8'h7f,8'h41,8'h41,8'h00},
    '{8'h00,8'h55,8'h2a,8'h55,8'h2a,8'h55}, '{8'h00,8'h00,8'h41,8'h41,8'h7f,8'h00},
    '{8'h00,8'h04,8'h02,8'h01,8'h02,8'h04}, '{8'h00,8'h40,8'h40,8'h40,8'h40,8'h40},
    '{8'h00,8'h00,8'h01,8'h02,8'h04,8'h00}, '{8'h00,8'h20,8'h54,8'h54,8'h54,8'h78},
    '{8'h00,8'h7f,8'h48,8'h44,8'h44,8'h38}, '{8'h00,8'h38,8'h44,8'h44,8'h44,8'h20},
    '{8'h00,8'h38,8'h44,8'h44,8'h48,8'h7f}, '{8'h00,8'h38,8'h54,8'h54,8'h54,8'h18},
    '{8'h00,8'h08,8'h7e,8'h09,8'h01,8'h02}, '{8'h00,8'h18,8'ha4,8'ha4,8'ha4,8'h7c},
    '{8'h00,8'h7f,8'h08,8'h04,8'h04,8'h78}, '{8'h00,8'h00,8'h44,8'h7d,8'h40,8'h00},
    '{8'h00,8'h40,8'h80,8'h84,8'h7d,8'h00}, '{8'h00,8'h7f,8'h10,8'h28,8'h44,8'h00},
    '{8'h00,8'h00,8'h41,8'h7f,8'h40,8'h00}, '{8'h00,8'h7c,8'h04,8'h18,8'h04,8'h78},
    '{8'h00,8'h7c,8'h08,8'h04,8'h04,8'h78}, '{8'h00,8'h38,8'h44,8'h44,8'h44,8'h38},
    '{8'h00,8'hfc,8'h24,8'h24,8'h24,8'h18}, '{8'h00,8'h18,8'h24,8'h24,8'h18,8'hfc},
    '{8'h00,8'h7c,8'h08,8'h04,8'h04,8'h08}, '{8'h00,8'h48,8'h54,8'h54,8'h54,8'h20},
    '{8'h00,8'h04,8'h3f,8'h44,8'h40,8'h20}, '{8'h00,8'h3c,8'h40,8'h40,8'h20,8'h7c},
    '{8'h00,8'h1c,8'h20,8'h40,8'h20,8'h1c}, '{8'h00,8'h3c,8'h40,8'h30,8'h40,8'h3c},
    '{8'h00,8'h44,8'h28,8'h10,8'h28,8'h44}, '{8'h00,8'h1c,8'ha0,8'ha0,8'ha0,8'h7c},
    '{8'h00,8'h44,8'h64,8'h54,8'h4c,8'h44}, '{8'h14,8'h14,8'h14,8'h14,8'h14,8'h14}
  };

endpackage

`default_nettype wire

// ===== rtl/core/gtpr_if.sv =====
// gtpr_char_if and gtpr_pix_if: valid/ready request channels of the glyph text renderer
// depends on nothing but the handshake convention of the top level
`default_nettype none

interface gtpr_char_if;
  logic        valid;
  logic        ready;
  logic        start_new_text;
  logic [15:0] origin_x;
  logic [15:0] origin_y;
  logic [7:0]  char_code;
  logic [15:0] foreground;
  logic [15:0] background;

  modport source (
    output valid, start_new_text, origin_x, origin_y, char_code, foreground, background,
    input  ready
  );
  modport sink (
    input  valid, start_new_text, origin_x, origin_y, char_code, foreground, background,
    output ready
  );
endinterface

interface gtpr_pix_if;
  logic        valid;
  logic        ready;
  logic [15:0] panel_x;
  logic [15:0] panel_y;
  logic [15:0] pixel_color;
  logic        last_pixel;

  modport source (output valid, panel_x, panel_y, pixel_color, last_pixel, input ready);
  modport sink   (input  valid, panel_x, panel_y, pixel_color, last_pixel, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/glyph_text_pixel_renderer_top.sv =====
// glyph_text_pixel_renderer_top: 6x8 font text renderer, one character request in,
// a stream of pixel write requests out; uses gtpr_pkg and the gtpr_if interfaces
`default_nettype none

// Each character request is checked against the text state (cursor, count, stop) in the
// cycle it is accepted; the state updates at once, so requests are accepted back to back
// while the job buffer has room, also while earlier characters are still being drawn. The
// glyph is read from the font table and registered into a one-entry job buffer, and a pixel
// walker then visits the 48 glyph positions column by column, top row first, one position
// per cycle unless stalled, emitting a write for each visible pixel and stopping at the last
// visible one. Stopped, disabled or fully clipped characters never reach the walker and
// emit nothing. The walker stalls while the output register holds an unaccepted write.
// Configuration must be written by the user only while the block is idle; the block
// itself does not enforce this.
module glyph_text_pixel_renderer_top #(
  parameter int unsigned MAX_TEXT_CHARS = 32,
  parameter int unsigned GLYPH_COUNT    = 92,
  parameter int unsigned CHAR_ADVANCE   = 7
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [gtpr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire [gtpr_pkg::CFG_W-1:0]     cfg_wdata_i,
  gtpr_char_if.sink                    char_i,
  gtpr_pix_if.source                   pix_o
);
  import gtpr_pkg::*;

  // configuration registers
  logic [CFG_W-1:0] width_q, height_q, colofs_q, rowofs_q;
  logic             enable_q;

  // text state
  logic [CUR_W-1:0] cursor_q, cursor_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             stop_q, stop_d;

  // job buffer between acceptance and the pixel walker
  job_t job_q, job_d;
  logic job_v_q, job_v_d;

  // pixel walker
  job_t       walk_q;
  logic       walk_v_q, walk_v_d;
  logic [2:0] col_q, row_q;

  // output register
  logic        out_v_q;
  logic [15:0] out_x_q, out_y_q, out_c_q;
  logic        out_last_q;

  logic accept, render, load, step, vis, is_last;
  logic [CUR_W-1:0] cur;
  logic [CNT_W-1:0] cnt;
  logic             stp;
  logic [7:0]       code;
  logic [7:0]       gidx;
  logic [8:0]       code_ext;

  // ---------------- configuration port ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_W'(240);
      height_q <= CFG_W'(240);
      colofs_q <= '0;
      rowofs_q <= '0;
      enable_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WIDTH:  width_q  <= cfg_wdata_i;
        CFG_HEIGHT: height_q <= cfg_wdata_i;
        CFG_COLOFS: colofs_q <= cfg_wdata_i;
        CFG_ROWOFS: rowofs_q <= cfg_wdata_i;
        CFG_ENABLE: enable_q <= cfg_wdata_i[0];
        default:    ;
      endcase
    end
  end

  // ---------------- acceptance and text state ----------------
  // walker frees when it is idle or emits its final pixel
  assign step    = walk_v_q && (!out_v_q || pix_o.ready);
  assign vis     = walk_q.col_mask[col_q] && walk_q.row_mask[row_q];
  assign is_last = vis && (col_q == walk_q.last_col) && (row_q == walk_q.last_row);
  assign load    = job_v_q && (!walk_v_q || (step && is_last));

  assign char_i.ready = !job_v_q || load;
  assign accept       = char_i.valid && char_i.ready;

  always_comb begin
    // a start applies before the stop check
    cur = char_i.start_new_text ? char_i.origin_x : cursor_q;
    cnt = char_i.start_new_text ? '0 : count_q;
    stp = char_i.start_new_text ? 1'b0 : stop_q;

    // unknown codes draw the question mark
    code_ext = {1'b0, char_i.char_code};
    if (char_i.char_code < 8'(FIRST_CODE) || code_ext >= 9'(FIRST_CODE + GLYPH_COUNT)) begin
      code = QMARK_CODE;
    end else begin
      code = char_i.char_code;
    end
    gidx = code - 8'(FIRST_CODE);

    cursor_d = cursor_q;
    count_d  = count_q;
    stop_d   = stop_q;
    if (accept && !stp) begin
      cursor_d = cur + CUR_W'(CHAR_ADVANCE);
      count_d  = cnt + CNT_W'(1);
      stop_d   = (count_d >= CNT_W'(MAX_TEXT_CHARS)) ||
                 (({1'b0, cursor_d} + {1'b0, STOP_MARGIN}) >= 17'(width_q));
    end

    // font table lookup; rows past the table read blank
    for (int c = 0; c < GLYPH_COLS; c++) begin
      job_d.glyph[c] = (gidx < 8'(ROM_ROWS)) ? FONT_ROM[gidx[6:0]][c] : 8'h00;
    end

    // clip masks and the position of the last visible pixel
    for (int c = 0; c < GLYPH_COLS; c++) begin
      job_d.col_mask[c] = (cur + CUR_W'(c)) < CUR_W'(width_q);
    end
    for (int r = 0; r < GLYPH_ROWS; r++) begin
      job_d.row_mask[r] = (char_i.origin_y + CUR_W'(r)) < CUR_W'(height_q);
    end
    job_d.last_col = '0;
    for (int c = 0; c < GLYPH_COLS; c++) begin
      if (job_d.col_mask[c]) job_d.last_col = 3'(c);
    end
    job_d.last_row = '0;
    for (int r = 0; r < GLYPH_ROWS; r++) begin
      if (job_d.row_mask[r]) job_d.last_row = 3'(r);
    end
    job_d.base_x = cur + CUR_W'(colofs_q);
    job_d.base_y = char_i.origin_y + CUR_W'(rowofs_q);
    job_d.fg     = char_i.foreground;
    job_d.bg     = char_i.background;

    // only characters with at least one visible pixel reach the walker
    render  = accept && !stp && enable_q && (|job_d.col_mask) && (|job_d.row_mask);
    job_v_d = render ? 1'b1 : (load ? 1'b0 : job_v_q);
    walk_v_d = load ? 1'b1 : ((step && is_last) ? 1'b0 : walk_v_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
      count_q  <= '0;
      stop_q   <= 1'b1;
      job_v_q  <= 1'b0;
      walk_v_q <= 1'b0;
    end else begin
      cursor_q <= cursor_d;
      count_q  <= count_d;
      stop_q   <= stop_d;
      job_v_q  <= job_v_d;
      walk_v_q <= walk_v_d;
    end
  end

  // font table read, registered into the job buffer
  always_ff @(posedge clk_i) begin
    if (render) begin
      job_q <= job_d;
    end
  end

  // ---------------- pixel walker ----------------
  always_ff @(posedge clk_i) begin
    if (load) begin
      walk_q <= job_q;
      col_q  <= '0;
      row_q  <= '0;
    end else if (step) begin
      if (row_q == 3'(GLYPH_ROWS - 1)) begin
        row_q <= '0;
        col_q <= col_q + 3'd1;
      end else begin
        row_q <= row_q + 3'd1;
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (step && vis) begin
      out_v_q <= 1'b1;
    end else if (pix_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && vis) begin
      out_x_q    <= walk_q.base_x + 16'(col_q);
      out_y_q    <= walk_q.base_y + 16'(row_q);
      out_c_q    <= walk_q.glyph[col_q][row_q] ? walk_q.fg : walk_q.bg;
      out_last_q <= is_last;
    end
  end

  assign pix_o.valid       = out_v_q;
  assign pix_o.panel_x     = out_x_q;
  assign pix_o.panel_y     = out_y_q;
  assign pix_o.pixel_color = out_c_q;
  assign pix_o.last_pixel  = out_last_q;

endmodule

`default_nettype wire

// ===== tb/glyph_text_pixel_renderer_top_test.sv =====
// testbench for glyph_text_pixel_renderer_top: drives character requests, predicts the
// pixel write requests they cause and checks each one in order
// depends on gtpr_pkg, gtpr_if.sv and the top level of the renderer
`timescale 1ns / 1ps

module glyph_text_pixel_renderer_top_test;
  import gtpr_pkg::*;

  // block parameters, kept at their defaults
  localparam int unsigned TEXT_CHAR_LIMIT = 32;
  localparam int unsigned GLYPH_CODES     = 92;
  localparam int unsigned ADVANCE         = 7;

  // drain time for the walker and the output register after the last prediction
  localparam int unsigned DRAIN_CYCLES    = 64;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned WATCHDOG_LIMIT  = 4000;
  localparam int unsigned MAX_GAP         = 17;

  typedef struct packed {
    logic        start;
    logic [15:0] ox;
    logic [15:0] oy;
    logic [7:0]  code;
    logic [15:0] fg;
    logic [15:0] bg;
  } char_req_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] color;
    logic        last;
  } pixel_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;

  gtpr_char_if char_bus ();
  gtpr_pix_if  pix_bus ();

  glyph_text_pixel_renderer_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .char_i      (char_bus.sink),
    .pix_o       (pix_bus.source)
  );

  // shadow of the configuration registers
  logic [8:0] disp_width;
  logic [8:0] disp_height;
  logic [8:0] col_ofs;
  logic [8:0] row_ofs;
  logic       disp_enable;

  // shadow of the text state
  logic [15:0] cursor;
  logic        stopped;
  logic [5:0]  char_count;

  pixel_t expected_pixels[$];
  int unsigned fail_count;
  int unsigned chars_sent;

  // idling control: quiet stretches on either side, one long receiver hold-off
  bit tx_quiet;
  bit rx_quiet;
  bit hold_off_req;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // work out the pixel writes of one accepted character and advance the text state
  function automatic void draw_char(char_req_t r);
    pixel_t      pend [48];
    int          n;
    logic [7:0]  code;
    logic [7:0]  bits;
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  idx;
    n = 0;
    if (r.start) begin
      cursor     = r.ox;
      char_count = '0;
      stopped    = 1'b0;
    end
    if (stopped) return;
    code = r.code;
    // unknown codes fall back to the question mark
    if (code < 8'(FIRST_CODE) || {1'b0, code} >= 9'(FIRST_CODE + GLYPH_CODES))
      code = QMARK_CODE;
    idx = code - 8'(FIRST_CODE);
    if (disp_enable) begin
      for (int col = 0; col < GLYPH_COLS; col++) begin
        // rows past the table come out as all background
        bits = (idx < 8'(ROM_ROWS)) ? FONT_ROM[idx[6:0]][col] : 8'h00;
        x = cursor + 16'(col);
        for (int row = 0; row < GLYPH_ROWS; row++) begin
          y = r.oy + 16'(row);
          if (x >= {7'd0, disp_width} || y >= {7'd0, disp_height}) continue;
          pend[n].x     = x + {7'd0, col_ofs};
          pend[n].y     = y + {7'd0, row_ofs};
          pend[n].color = bits[row] ? r.fg : r.bg;
          pend[n].last  = 1'b0;
          n++;
        end
      end
      if (n > 0) pend[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) expected_pixels.push_back(pend[i]);
    end
    cursor     = cursor + 16'(ADVANCE);
    char_count = char_count + 6'd1;
    // the edge test is done on the unwrapped sum
    if (char_count >= 6'(TEXT_CHAR_LIMIT) || ({1'b0, cursor} + 17'd6 >= {8'd0, disp_width}))
      stopped = 1'b1;
  endfunction

  // compare one accepted pixel write with the oldest prediction
  function automatic void check_pixel();
    pixel_t exp_pix;
    if (expected_pixels.size() == 0) begin
      $error("unexpected pixel write x=%h y=%h color=%h last=%b", pix_bus.panel_x,
             pix_bus.panel_y, pix_bus.pixel_color, pix_bus.last_pixel);
      fail_count++;
      return;
    end
    exp_pix = expected_pixels.pop_front();
    if (pix_bus.panel_x !== exp_pix.x) begin
      $error("panel_x expected %h got %h", exp_pix.x, pix_bus.panel_x);
      fail_count++;
    end
    if (pix_bus.panel_y !== exp_pix.y) begin
      $error("panel_y expected %h got %h", exp_pix.y, pix_bus.panel_y);
      fail_count++;
    end
    if (pix_bus.pixel_color !== exp_pix.color) begin
      $error("pixel_color expected %h got %h", exp_pix.color, pix_bus.pixel_color);
      fail_count++;
    end
    if (pix_bus.last_pixel !== exp_pix.last) begin
      $error("last_pixel expected %b got %b", exp_pix.last, pix_bus.last_pixel);
      fail_count++;
    end
  endfunction

  // offer one character request after a random gap and predict it once accepted
  task automatic send_char(char_req_t r);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk_i);
    if (gap != 0) begin
      char_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    char_bus.start_new_text <= r.start;
    char_bus.origin_x       <= r.ox;
    char_bus.origin_y       <= r.oy;
    char_bus.char_code      <= r.code;
    char_bus.foreground     <= r.fg;
    char_bus.background     <= r.bg;
    char_bus.valid          <= 1'b1;
    do @(posedge clk_i); while (!char_bus.ready);
    draw_char(r);
    chars_sent++;
  endtask

  function automatic char_req_t make_char(logic start, logic [15:0] ox, logic [15:0] oy,
                                          logic [7:0] code);
    char_req_t r;
    r.start = start;
    r.ox    = ox;
    r.oy    = oy;
    r.code  = code;
    r.fg    = 16'($urandom);
    r.bg    = 16'($urandom);
    return r;
  endfunction

  // mostly printable codes, the rest anything a byte can hold
  function automatic logic [7:0] rand_code();
    if ($urandom_range(0, 7) == 0) return 8'($urandom);
    return 8'($urandom_range(FIRST_CODE, FIRST_CODE + GLYPH_CODES - 1));
  endfunction

  // all requests accepted, all predictions seen, walker given time to finish
  task automatic wait_idle();
    @(negedge clk_i);
    char_bus.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [8:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CFG_WIDTH:  disp_width  = value;
      CFG_HEIGHT: disp_height = value;
      CFG_COLOFS: col_ofs     = value;
      CFG_ROWOFS: row_ofs     = value;
      CFG_ENABLE: disp_enable = value[0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(logic [8:0] w, logic [8:0] h, logic [8:0] co,
                               logic [8:0] ro, logic en);
    wait_idle();
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_COLOFS, co);
    write_reg(CFG_ROWOFS, ro);
    write_reg(CFG_ENABLE, {8'd0, en});
  endtask

  // one text string: a start, then plain characters, now and then a restart
  task automatic send_string(logic [15:0] ox, logic [15:0] oy, int unsigned len);
    logic [15:0] row_y;
    row_y = oy;
    send_char(make_char(1'b1, ox, row_y, rand_code()));
    for (int i = 1; i < len; i++) begin
      if ($urandom_range(0, 7) == 0) row_y = 16'($urandom);
      if ($urandom_range(0, 15) == 0)
        send_char(make_char(1'b1, 16'($urandom_range(0, 320)), row_y, rand_code()));
      else
        send_char(make_char(1'b0, 16'($urandom), row_y, rand_code()));
    end
  endtask

  // after reset the text is stopped and the panel disabled; a disabled panel still
  // moves the cursor
  task automatic test_reset_state();
    send_char(make_char(1'b0, 16'd0, 16'd0, 8'h41));
    send_char(make_char(1'b1, 16'd0, 16'd0, 8'h41));
    wait_idle();
    write_reg(CFG_ENABLE, 9'd1);
    // drawn at the second cell of the string
    send_char(make_char(1'b0, 16'hffff, 16'd10, 8'h42));
  endtask

  // code range edges, question mark fallback and extreme colors
  task automatic test_glyph_codes();
    char_req_t r;
    apply_setting(9'd240, 9'd240, 9'd0, 9'd0, 1'b1);
    r = make_char(1'b1, 16'd0, 16'd0, 8'd32);
    r.fg = 16'hffff;
    r.bg = 16'h0000;
    send_char(r);
    r = make_char(1'b0, 16'd0, 16'd0, 8'd33);
    r.fg = 16'h0000;
    r.bg = 16'hffff;
    send_char(r);
    send_char(make_char(1'b0, 16'hffff, 16'd0, 8'd123));
    send_char(make_char(1'b0, 16'h0000, 16'd0, 8'd124));
    send_char(make_char(1'b0, 16'h5555, 16'd0, 8'd31));
    send_char(make_char(1'b0, 16'haaaa, 16'd0, 8'd0));
    send_char(make_char(1'b0, 16'd0, 16'hffff, 8'd255));
    send_char(make_char(1'b0, 16'd0, 16'd232, 8'h41));
  endtask

  // clipping at the right and bottom edges, coordinate wrap, full clip, tiny panel
  task automatic test_clip_edges();
    apply_setting(9'd320, 9'd320, 9'd319, 9'd319, 1'b1);
    // only three columns fit, then the text stops at the edge
    send_char(make_char(1'b1, 16'd317, 16'd100, 8'h48));
    // cursor wraps into the visible area and the text goes on
    send_char(make_char(1'b1, 16'd65533, 16'd65533, 8'h23));
    send_char(make_char(1'b0, 16'd0, 16'd316, 8'h23));
    // below the last row: nothing drawn, string continues
    send_char(make_char(1'b0, 16'd0, 16'd320, 8'h40));
    send_char(make_char(1'b1, 16'd320, 16'd0, 8'h40));
    apply_setting(9'd1, 9'd1, 9'd0, 9'd0, 1'b1);
    send_char(make_char(1'b1, 16'd0, 16'd0, 8'h5f));
    send_char(make_char(1'b1, 16'd0, 16'd0, 8'h20));
  endtask

  // a zero width or height drops every pixel
  task automatic test_zero_size();
    apply_setting(9'd0, 9'd240, 9'd0, 9'd0, 1'b1);
    send_char(make_char(1'b1, 16'd0, 16'd0, 8'h41));
    send_char(make_char(1'b0, 16'd0, 16'd0, 8'h41));
    apply_setting(9'd240, 9'd0, 9'd0, 9'd0, 1'b1);
    send_char(make_char(1'b1, 16'd0, 16'd0, 8'h41));
    send_char(make_char(1'b0, 16'd0, 16'd0, 8'h41));
  endtask

  // receiver holds off while requests keep coming, so the input has to stall
  task automatic test_backpressure();
    apply_setting(9'd240, 9'd240, 9'd0, 9'd0, 1'b1);
    tx_quiet     = 1'b1;
    hold_off_req = 1'b1;
    send_string(16'd0, 16'($urandom_range(0, 232)), 20);
    tx_quiet     = 1'b0;
  endtask

  // random strings under a series of register settings
  task automatic test_config_sweep();
    logic [8:0]  w;
    logic [8:0]  h;
    int unsigned phase_start;
    int unsigned kind;
    for (int phase = 0; phase < 9; phase++) begin
      case (phase)
        0: apply_setting(9'd240, 9'd240, 9'd0, 9'd0, 1'b1);
        1: apply_setting(9'd320, 9'd320, 9'd319, 9'd319, 1'b1);
        2: apply_setting(9'd1, 9'd1, 9'd0, 9'd0, 1'b1);
        3: apply_setting(9'd240, 9'd240, 9'd17, 9'd3, 1'b0);
        default: begin
          w = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(1, 320))
                                          : 9'($urandom_range(230, 320));
          h = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(1, 320))
                                          : 9'($urandom_range(8, 320));
          apply_setting(w, h, 9'($urandom_range(0, 319)), 9'($urandom_range(0, 319)), 1'b1);
        end
      endcase
      tx_quiet    = ($urandom_range(0, 3) == 0);
      phase_start = chars_sent;
      while (chars_sent - phase_start < 20) begin
        kind = $urandom_range(0, 9);
        if (kind <= 6) begin
          // well formed text on the panel, at times long enough to hit the count limit
          send_string(16'($urandom_range(0, disp_width)),
                      16'($urandom_range(0, disp_height)), $urandom_range(1, 36));
        end else if (kind == 7) begin
          // loose characters with no start, ignored once the text has stopped
          repeat ($urandom_range(1, 4))
            send_char(make_char(1'b0, 16'($urandom), 16'($urandom), 8'($urandom)));
        end else if (kind == 8) begin
          send_string(16'($urandom), 16'($urandom), $urandom_range(1, 4));
        end else begin
          // origin just left of zero so the columns wrap into view
          send_string(16'hffff - 16'($urandom_range(0, 8)),
                      ($urandom_range(0, 1) == 0) ? 16'hffff - 16'($urandom_range(0, 8))
                                                  : 16'($urandom_range(0, 16)),
                      $urandom_range(1, 8));
        end
      end
      tx_quiet = 1'b0;
    end
  endtask

  // pixel sink: random stalls per write, quiet stretches, one long hold-off
  initial begin : pixel_sink
    int unsigned stall;
    pix_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 99) == 0) rx_quiet = !rx_quiet;
      if (hold_off_req) begin
        stall        = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end else begin
        stall = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
      end
      @(negedge clk_i);
      if (stall != 0) begin
        pix_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      pix_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!pix_bus.valid);
      check_pixel();
    end
  end

  // watchdog: too long without any request moving on either side
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((char_bus.valid && char_bus.ready) || (pix_bus.valid && pix_bus.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("glyph_text_pixel_renderer_top regression: fail");
    $finish;
  end

  initial begin
    // every input known from time zero
    rst_ni                  = 1'b0;
    cfg_we_i                = 1'b0;
    cfg_idx_i               = CFG_WIDTH;
    cfg_wdata_i             = '0;
    char_bus.valid          = 1'b0;
    char_bus.start_new_text = 1'b0;
    char_bus.origin_x       = '0;
    char_bus.origin_y       = '0;
    char_bus.char_code      = '0;
    char_bus.foreground     = '0;
    char_bus.background     = '0;
    tx_quiet                = 1'b0;
    rx_quiet                = 1'b0;
    hold_off_req            = 1'b0;
    fail_count              = 0;
    chars_sent              = 0;
    // reset values of the registers and the text state
    disp_width  = 9'd240;
    disp_height = 9'd240;
    col_ofs     = 9'd0;
    row_ofs     = 9'd0;
    disp_enable = 1'b0;
    cursor      = '0;
    stopped     = 1'b1;
    char_count  = '0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_glyph_codes();
    test_clip_edges();
    test_zero_size();
    test_backpressure();
    test_config_sweep();

    wait_idle();
    if (fail_count == 0) begin
      $display("glyph_text_pixel_renderer_top regression: pass");
    end else begin
      $display("glyph_text_pixel_renderer_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/gtpr_pkg.sv
rtl/core/gtpr_if.sv
rtl/core/glyph_text_pixel_renderer_top.sv
tb/glyph_text_pixel_renderer_top_test.sv
